>>> hdl/gds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gds_pkg
// Shared constants and types for the grid diffusion stencil.
// ----------------------------------------------------------------------------
package gds_pkg;

	localparam int N          = 32;
	localparam int CELLS      = N * N;
	localparam int POS_W      = $clog2(N);
	localparam int CELL_W     = $clog2(CELLS);
	localparam int HALO_DEPTH = 4 * N;
	localparam int HALO_W     = $clog2(HALO_DEPTH);
	localparam int WORD_W     = 32;
	localparam int LEVEL_W    = 16;
	localparam int RATE_W     = 17;
	localparam int SUM_W      = LEVEL_W + 3;
	localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(65536);

	typedef enum logic [1:0] {
		ACT_WRITE_CELL = 2'd0,
		ACT_WRITE_HALO = 2'd1,
		ACT_TICK       = 2'd2,
		ACT_READ_CELL  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		SIDE_N = 2'd0,
		SIDE_S = 2'd1,
		SIDE_E = 2'd2,
		SIDE_W = 2'd3
	} side_t;

	localparam logic [1:0] REG_ALPHA = 2'd0;
	localparam logic [1:0] REG_BETA  = 2'd1;
	localparam logic [1:0] REG_MAX   = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_FETCH,
		ST_WAIT,
		ST_ACCUM,
		ST_MIX_A,
		ST_MIX_B,
		ST_SCALE,
		ST_ROUND,
		ST_STORE,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_DONE
	} state_t;

endpackage

>>> hdl/gds_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gds_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module gds_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

>>> hdl/grid_diffusion_stencil_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_diffusion_stencil_top
// Eight-neighbour diffusion and evaporation over a 32 x 32 two-channel grid.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// appears later on home_out and food_out with done high for one cycle, and the
// receiver cannot stall it. A tick walks the grid one cell at a time through a
// single shared datapath: each cell takes 8 neighbour fetches plus one fetch of
// the cell itself (one port of the cell RAM and one of the halo RAM, read data
// registered), then per channel three steps on the one shared multiplier and a
// rounding step, and one write to the next-state RAM. A copy back into the cell
// RAM follows, one read state and one write state per cell, and then the
// result. After reset the block clears the cell RAM and halo RAM in one pass
// over the cell addresses with busy high; configuration writes are still taken
// then.
// ----------------------------------------------------------------------------
module grid_diffusion_stencil_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	output logic                        done,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [16:0]                 cfg_data,
	input  logic [1:0]                  action,
	input  logic [9:0]                  cell_index,
	input  logic [1:0]                  halo_side,
	input  logic [4:0]                  edge_position,
	input  logic [15:0]                 home_level,
	input  logic [15:0]                 food_level,
	input  logic [3:0]                  neighbour_present,
	output logic [15:0]                 home_out,
	output logic [15:0]                 food_out
);
	import gds_pkg::*;

	// Configuration registers.
	logic [RATE_W-1:0]  alpha_q, beta_q;
	logic [LEVEL_W-1:0] max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= '0;
			beta_q  <= RATE_ONE;
			max_q   <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ALPHA: alpha_q <= cfg_data;
				REG_BETA:  beta_q  <= cfg_data;
				REG_MAX:   max_q   <= cfg_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	state_t state_q, state_d;

	// A request is taken only when the port shows the block as free.
	logic accept;
	assign accept = start && !busy;

	// Captured request.
	action_t            act_q;
	logic [9:0]         cidx_q;
	logic [1:0]         side_q;
	logic [4:0]         pos_q;
	logic [WORD_W-1:0]  word_q;
	logic [3:0]         pres_q;

	// Sweep state.
	logic [CELL_W:0]    cnt_q;        // cell counter, also clearing counter
	logic [3:0]         k_q;          // neighbour index, 8 means self
	logic               use_halo_q;
	logic [SUM_W-1:0]   sh_q, sf_q;
	logic [WORD_W-1:0]  self_q;
	logic [RATE_W-1:0]  a_q, b_q;
	logic               ch_q;         // channel being blended: 0 home, 1 food
	logic [35:0]        mix_q;
	logic [51:0]        prod_q;
	logic [LEVEL_W-1:0] res_h_q;
	logic [15:0]        rd_h_q, rd_f_q;

	// RAM ports.
	logic               cell_we, halo_we, next_we;
	logic [CELL_W-1:0]  cell_addr, next_addr;
	logic [HALO_W-1:0]  halo_addr;
	logic [WORD_W-1:0]  cell_wdata, halo_wdata, next_wdata;
	logic [WORD_W-1:0]  cell_rdata, halo_rdata, next_rdata;

	gds_ram #(.WIDTH(WORD_W), .DEPTH(CELLS)) u_cell (
		.clk(clk), .we(cell_we), .addr(cell_addr), .wdata(cell_wdata), .rdata(cell_rdata));
	gds_ram #(.WIDTH(WORD_W), .DEPTH(HALO_DEPTH)) u_halo (
		.clk(clk), .we(halo_we), .addr(halo_addr), .wdata(halo_wdata), .rdata(halo_rdata));
	gds_ram #(.WIDTH(WORD_W), .DEPTH(CELLS)) u_next (
		.clk(clk), .we(next_we), .addr(next_addr), .wdata(next_wdata), .rdata(next_rdata));

	// Neighbour address generation for neighbour k of the current cell.
	logic [POS_W-1:0] row, col;
	logic signed [POS_W+1:0] nr, nc;
	logic [POS_W-1:0] pr, pc;
	logic nb_halo;
	logic [1:0] nb_side;
	logic [CELL_W-1:0] nb_cell;
	logic [HALO_W-1:0] nb_halo_addr;

	assign row = cnt_q[CELL_W-1:POS_W];
	assign col = cnt_q[POS_W-1:0];

	always_comb begin
		logic signed [POS_W+1:0] dr, dc;
		dr = '0;
		dc = '0;
		case (k_q)
			4'd0: begin dc = -1; dr = -1; end
			4'd1: begin dc = 0;  dr = -1; end
			4'd2: begin dc = 1;  dr = -1; end
			4'd3: begin dc = -1; dr = 0;  end
			4'd4: begin dc = 1;  dr = 0;  end
			4'd5: begin dc = -1; dr = 1;  end
			4'd6: begin dc = 0;  dr = 1;  end
			4'd7: begin dc = 1;  dr = 1;  end
			default: begin dc = 0; dr = 0; end
		endcase
		nr = $signed({2'b00, row}) + dr;
		nc = $signed({2'b00, col}) + dc;
		pr = (nr < 0) ? '0 : (nr > N - 1) ? POS_W'(N - 1) : nr[POS_W-1:0];
		pc = (nc < 0) ? '0 : (nc > N - 1) ? POS_W'(N - 1) : nc[POS_W-1:0];
		nb_halo = 1'b0;
		nb_side = SIDE_N;
		if (nr < 0) begin
			nb_side = SIDE_N;
			nb_halo = pres_q[0];
		end else if (nr > N - 1) begin
			nb_side = SIDE_S;
			nb_halo = pres_q[1];
		end else if (nc > N - 1) begin
			nb_side = SIDE_E;
			nb_halo = pres_q[2];
		end else if (nc < 0) begin
			nb_side = SIDE_W;
			nb_halo = pres_q[3];
		end
		nb_cell = {pr, pc};
		nb_halo_addr = (nb_side == SIDE_N || nb_side == SIDE_S) ?
			{nb_side, pc} : {nb_side, pr};
	end

	// Shared multiplier: one 36 x 17 step per cycle, operands chosen by state.
	logic [WORD_W-1:0] nb_word;
	logic [LEVEL_W-1:0] self_lvl;
	logic [SUM_W-1:0]   sum_lvl;
	assign nb_word  = use_halo_q ? halo_rdata : cell_rdata;
	assign self_lvl = ch_q ? self_q[31:16] : self_q[15:0];
	assign sum_lvl  = ch_q ? sf_q : sh_q;

	logic [35:0] mul_x;
	logic [16:0] mul_y;
	logic [52:0] mul_p;

	always_comb begin
		mul_x = 36'({self_lvl, 3'b000});
		mul_y = RATE_ONE - a_q;
		case (state_q)
			ST_MIX_B: begin
				mul_x = 36'(sum_lvl);
				mul_y = a_q;
			end
			ST_SCALE: begin
				mul_x = mix_q;
				mul_y = b_q;
			end
			default: ;
		endcase
	end

	assign mul_p = 53'(mul_x) * 53'(mul_y);

	logic [51:0] rounded;
	logic [LEVEL_W-1:0] clamped;
	assign rounded = (prod_q + 52'(35'h4_0000_0000)) >> 35;
	assign clamped = (rounded > 52'(max_q)) ? max_q : rounded[LEVEL_W-1:0];

	always_comb begin
		state_d    = state_q;
		cell_we    = 1'b0;
		halo_we    = 1'b0;
		next_we    = 1'b0;
		cell_addr  = nb_cell;
		halo_addr  = nb_halo_addr;
		next_addr  = cnt_q[CELL_W-1:0];
		cell_wdata = word_q;
		halo_wdata = word_q;
		next_wdata = {clamped, res_h_q};
		unique case (state_q)
			ST_IDLE: if (accept) begin
				unique case (action_t'(action))
					ACT_TICK: state_d = ST_FETCH;
					default:  state_d = ST_WAIT;
				endcase
			end
			ST_CLEAR: begin
				cell_we    = 1'b1;
				cell_addr  = cnt_q[CELL_W-1:0];
				cell_wdata = '0;
				halo_we    = 1'b1;
				halo_addr  = cnt_q[HALO_W-1:0];
				halo_wdata = '0;
				if (cnt_q == (CELL_W+1)'(CELLS - 1)) state_d = ST_IDLE;
			end
			ST_WAIT: begin
				// Single access for write and read requests.
				cell_addr = cidx_q[CELL_W-1:0];
				halo_addr = {side_q, pos_q[POS_W-1:0]};
				cell_we = (act_q == ACT_WRITE_CELL) && ({1'b0, cidx_q} < 11'(CELLS));
				halo_we = (act_q == ACT_WRITE_HALO) && ({1'b0, pos_q} < 6'(N));
				state_d = ST_DONE;
			end
			ST_FETCH: begin
				if (k_q == 4'd8) cell_addr = cnt_q[CELL_W-1:0];
				state_d = ST_ACCUM;
			end
			ST_ACCUM: begin
				if (k_q == 4'd8) state_d = ST_MIX_A;
				else begin
					if (k_q + 4'd1 == 4'd8) cell_addr = cnt_q[CELL_W-1:0];
					state_d = ST_FETCH;
				end
			end
			ST_MIX_A: state_d = ST_MIX_B;
			ST_MIX_B: state_d = ST_SCALE;
			ST_SCALE: state_d = ST_ROUND;
			ST_ROUND: state_d = ch_q ? ST_STORE : ST_MIX_A;
			ST_STORE: begin
				next_we = 1'b1;
				if (cnt_q == (CELL_W+1)'(CELLS - 1)) state_d = ST_COPY_RD;
				else state_d = ST_FETCH;
			end
			ST_COPY_RD: state_d = ST_COPY_WR;
			ST_COPY_WR: begin
				cell_we    = 1'b1;
				cell_addr  = cnt_q[CELL_W-1:0];
				cell_wdata = next_rdata;
				state_d = (cnt_q == (CELL_W+1)'(CELLS - 1)) ? ST_DONE : ST_COPY_RD;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			k_q     <= '0;
			ch_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					k_q   <= '0;
					ch_q  <= 1'b0;
				end
				ST_CLEAR: cnt_q <= (state_d == ST_IDLE) ? '0 : cnt_q + (CELL_W+1)'(1);
				ST_ACCUM: k_q <= (k_q == 4'd8) ? 4'd0 : k_q + 4'd1;
				ST_ROUND: ch_q <= ~ch_q;
				ST_STORE: cnt_q <= (state_d == ST_COPY_RD) ? '0 : cnt_q + (CELL_W+1)'(1);
				ST_COPY_WR: cnt_q <= cnt_q + (CELL_W+1)'(1);
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			act_q  <= action_t'(action);
			cidx_q <= cell_index;
			side_q <= halo_side;
			pos_q  <= edge_position;
			word_q <= {food_level, home_level};
			pres_q <= neighbour_present;
			a_q    <= (alpha_q > RATE_ONE) ? RATE_ONE : alpha_q;
			b_q    <= (beta_q > RATE_ONE) ? RATE_ONE : beta_q;
		end
		if (state_q == ST_FETCH) begin
			use_halo_q <= nb_halo;
			if (k_q == 4'd0) begin
				sh_q <= '0;
				sf_q <= '0;
			end
		end
		if (state_q == ST_ACCUM) begin
			if (k_q == 4'd8) self_q <= cell_rdata;
			else begin
				sh_q <= sh_q + SUM_W'(nb_word[15:0]);
				sf_q <= sf_q + SUM_W'(nb_word[31:16]);
			end
		end
		if (state_q == ST_MIX_A)
			mix_q <= mul_p[35:0];
		if (state_q == ST_MIX_B)
			mix_q <= mix_q + mul_p[35:0];
		if (state_q == ST_SCALE)
			prod_q <= mul_p[51:0];
		if (state_q == ST_ROUND && !ch_q)
			res_h_q <= clamped;
		if (state_q == ST_WAIT) begin
			rd_h_q <= '0;
			rd_f_q <= '0;
		end
		if (state_q == ST_DONE && act_q == ACT_READ_CELL && {1'b0, cidx_q} < 11'(CELLS)) begin
			rd_h_q <= cell_rdata[15:0];
			rd_f_q <= cell_rdata[31:16];
		end
	end

	// Result comes out in the cycle after the done state.
	logic done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= (state_q == ST_DONE);
	end

	assign busy     = (state_q != ST_IDLE) || done_q;
	assign done     = done_q;
	assign home_out = (act_q == ACT_READ_CELL) ? rd_h_q : '0;
	assign food_out = (act_q == ACT_READ_CELL) ? rd_f_q : '0;
endmodule

>>> hdl/gds_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gds_checker
// Port-level checks of the request and result timing.
// ----------------------------------------------------------------------------
module gds_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [15:0] home_out,
	input logic [15:0] food_out,
	input logic [1:0]  action
);
	import gds_pkg::*;

	// A result strobe lasts a single cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");

	// An accepted request makes the block busy next cycle.
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("not busy after request");

	// The block is busy while a result is shown.
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("idle with result");

	// A request with action other than read yields zero data.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action != ACT_READ_CELL) |=>
			##2 (done -> (home_out == 0 && food_out == 0)))
		else $error("nonzero data");
endmodule

bind grid_diffusion_stencil_top gds_checker u_gds_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.home_out(home_out), .food_out(food_out), .action(action));

>>> verif/grid_diffusion_stencil_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_diffusion_stencil_top_tb
// Self-checking bench for the two-channel grid diffusion stencil.
// ----------------------------------------------------------------------------
// Requests (cell writes, halo writes, reads and ticks) are driven with random
// gaps under several rate settings. A scoreboard class keeps its own copy of
// the grid, the halos and the registers, predicts the read-back of every
// request and checks each done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module grid_diffusion_stencil_top_tb;
	import gds_pkg::*;

	// One scoreboard holds the mirrored grid and the queue of predicted levels.
	class diffusion_scoreboard;
		bit [31:0] cells [CELLS];
		bit [31:0] halo [HALO_DEPTH];
		bit [16:0] alpha_reg;
		bit [16:0] beta_reg;
		bit [15:0] top_reg;
		bit [31:0] pending_levels [$];
		int        errors;

		function void reset_state();
			foreach (cells[i]) cells[i] = '0;
			foreach (halo[i]) halo[i] = '0;
			alpha_reg = 17'd0;
			beta_reg  = 17'd65536;
			top_reg   = 16'hFFFF;
			pending_levels.delete();
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [16:0] value);
			case (idx)
				REG_ALPHA: alpha_reg = value;
				REG_BETA:  beta_reg  = value;
				REG_MAX:   top_reg   = value[15:0];
				default: ;
			endcase
		endfunction

		// Off-grid neighbours come from a halo, or from the grid's own edge
		// when that side is not marked present. North and south own the corners.
		function bit [31:0] neighbour(int col, int row, bit [3:0] present);
			int p;
			if (col >= 0 && col < N && row >= 0 && row < N)
				return cells[row * N + col];
			if (row < 0 || row >= N) begin
				p = (col < 0) ? 0 : (col > N - 1) ? N - 1 : col;
				if (row < 0)
					return present[0] ? halo[p] : cells[p];
				return present[1] ? halo[N + p] : cells[(N - 1) * N + p];
			end
			p = (row < 0) ? 0 : (row > N - 1) ? N - 1 : row;
			if (col >= N)
				return present[2] ? halo[2 * N + p] : cells[p * N + N - 1];
			return present[3] ? halo[3 * N + p] : cells[p * N];
		endfunction

		function bit [15:0] blend(bit [15:0] self, bit [18:0] sum, bit [16:0] a, bit [16:0] b);
			longint unsigned mix;
			longint unsigned r;
			mix = longint'(self) * 8 * (65536 - longint'(a)) + longint'(a) * longint'(sum);
			r = (mix * longint'(b) + (64'd1 << 34)) >> 35;
			if (r > top_reg)
				r = top_reg;
			return r[15:0];
		endfunction

		function void run_tick(bit [3:0] present);
			bit [31:0] next_cells [CELLS];
			bit [16:0] a;
			bit [16:0] b;
			bit [18:0] sh;
			bit [18:0] sf;
			bit [31:0] w;
			a = (alpha_reg > 17'd65536) ? 17'd65536 : alpha_reg;
			b = (beta_reg > 17'd65536) ? 17'd65536 : beta_reg;
			for (int row = 0; row < N; row++) begin
				for (int col = 0; col < N; col++) begin
					sh = '0;
					sf = '0;
					for (int dr = -1; dr <= 1; dr++) begin
						for (int dc = -1; dc <= 1; dc++) begin
							if (dr != 0 || dc != 0) begin
								w = neighbour(col + dc, row + dr, present);
								sh += w[15:0];
								sf += w[31:16];
							end
						end
					end
					w = cells[row * N + col];
					next_cells[row * N + col] = {blend(w[31:16], sf, a, b),
						blend(w[15:0], sh, a, b)};
				end
			end
			cells = next_cells;
		endfunction

		function void note_request(logic [1:0] act, logic [9:0] ci, logic [1:0] sd,
				logic [4:0] pos, logic [15:0] h, logic [15:0] f, logic [3:0] present);
			bit [31:0] level_pair;
			level_pair = '0;
			case (act)
				ACT_WRITE_CELL: cells[ci] = {f, h};
				ACT_WRITE_HALO: halo[sd * N + pos] = {f, h};
				ACT_TICK:       run_tick(present);
				ACT_READ_CELL:  level_pair = cells[ci];
				default: ;
			endcase
			pending_levels.push_back(level_pair);
		endfunction

		function void check_result(logic [15:0] h, logic [15:0] f);
			bit [31:0] want;
			if (pending_levels.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("Unexpected result: home %h food %h", h, f);
				return;
			end
			want = pending_levels.pop_front();
			if (h !== want[15:0] || f !== want[31:16]) begin
				errors++;
				if (errors <= 10)
					$display("Mismatch: home %h (want %h), food %h (want %h)",
						h, want[15:0], f, want[31:16]);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        done;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [16:0] cfg_data;
	logic [1:0]  action;
	logic [9:0]  cell_index;
	logic [1:0]  halo_side;
	logic [4:0]  edge_position;
	logic [15:0] home_level;
	logic [15:0] food_level;
	logic [3:0]  neighbour_present;
	logic [15:0] home_out;
	logic [15:0] food_out;

	diffusion_scoreboard sb;
	bit          calm;
	int unsigned cycle_count;

	grid_diffusion_stencil_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.action(action), .cell_index(cell_index), .halo_side(halo_side),
		.edge_position(edge_position), .home_level(home_level),
		.food_level(food_level), .neighbour_present(neighbour_present),
		.home_out(home_out), .food_out(food_out)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// This limit only catches a hung block.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 4000000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Results are checked before the request of the same edge is noted. A
	// result can never belong to a request accepted at that very edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(home_out, food_out);
			if (start && !busy)
				sb.note_request(action, cell_index, halo_side, edge_position,
					home_level, food_level, neighbour_present);
		end
	end

	// Drive one request from a falling edge and hold it until it is taken.
	// The task returns on a falling edge so the next request follows at once.
	task automatic send(logic [1:0] act, logic [9:0] ci, logic [1:0] sd, logic [4:0] pos,
			logic [15:0] h, logic [15:0] f, logic [3:0] present);
		if (!calm && $urandom_range(0, 99) < 30) begin
			start = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		start             = 1'b1;
		action            = act;
		cell_index        = ci;
		halo_side         = sd;
		edge_position     = pos;
		home_level        = h;
		food_level        = f;
		neighbour_present = present;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		@(negedge clk);
	endtask

	// Let every outstanding result arrive before touching the registers.
	task automatic settle();
		start = 1'b0;
		while (sb.pending_levels.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [16:0] value);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		sb.set_reg(idx, value);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Levels lean toward the extremes and toward small values, where the
	// rounding and the clamp are most often exercised.
	function automatic logic [15:0] rand_level();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			1: return 16'($urandom_range(0, 511));
			default: return 16'($urandom);
		endcase
	endfunction

	// One random request. Ticks are rationed since each sweeps the whole grid.
	task automatic random_request(inout int ticks_left);
		int pick;
		logic [1:0] act;
		pick = $urandom_range(0, 99);
		if (pick < 3 && ticks_left > 0) begin
			act = ACT_TICK;
			ticks_left--;
		end else if (pick < 43)
			act = ACT_WRITE_CELL;
		else if (pick < 60)
			act = ACT_WRITE_HALO;
		else
			act = ACT_READ_CELL;
		send(act, 10'($urandom), 2'($urandom), 5'($urandom), rand_level(), rand_level(),
			4'($urandom));
	endtask

	task automatic random_phase(int count, int ticks);
		int ticks_left;
		ticks_left = ticks;
		for (int i = 0; i < count; i++) begin
			calm = (i >= count / 3 && i < count / 2);
			random_request(ticks_left);
		end
		calm = 1'b0;
		// Close each phase with a tick and reads so diffused data is observed.
		send(ACT_TICK, 10'($urandom), 2'($urandom), 5'($urandom), 16'($urandom),
			16'($urandom), 4'($urandom));
		repeat (6)
			send(ACT_READ_CELL, 10'($urandom), 2'($urandom), 5'($urandom), 16'($urandom),
				16'($urandom), 4'($urandom));
		settle();
	endtask

	initial begin
		sb = new();
		sb.reset_state();
		cycle_count       = 0;
		calm              = 1'b0;
		arst_n            = 1'b0;
		start             = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = REG_ALPHA;
		cfg_data          = '0;
		action            = ACT_READ_CELL;
		cell_index        = '0;
		halo_side         = SIDE_N;
		edge_position     = '0;
		home_level        = '0;
		food_level        = '0;
		neighbour_present = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Half-rate diffusion for the directed part; the clearing pass after
		// reset still accepts register writes.
		write_reg(REG_ALPHA, 17'd32768);

		// Corners and edges of the grid, and one entry per halo side at the
		// ends of its run, then ticks with every side present and none present.
		send(ACT_WRITE_CELL, 10'd0, SIDE_N, 5'd0, 16'hFFFF, 16'hFFFF, 4'h0);
		send(ACT_WRITE_CELL, 10'd1023, SIDE_W, 5'd31, 16'h1234, 16'hFFFF, 4'hF);
		send(ACT_WRITE_CELL, 10'd31, SIDE_S, 5'd0, 16'h0000, 16'h8001, 4'h0);
		send(ACT_WRITE_CELL, 10'd992, SIDE_E, 5'd31, 16'hFFFF, 16'h0000, 4'h0);
		send(ACT_WRITE_HALO, 10'd0, SIDE_N, 5'd0, 16'hFFFF, 16'h00FF, 4'h0);
		send(ACT_WRITE_HALO, 10'd0, SIDE_S, 5'd31, 16'hFFFF, 16'hFFFF, 4'h0);
		send(ACT_WRITE_HALO, 10'd0, SIDE_E, 5'd0, 16'h0100, 16'hFFFF, 4'h0);
		send(ACT_WRITE_HALO, 10'd1023, SIDE_W, 5'd31, 16'hFFFF, 16'h0001, 4'hF);
		send(ACT_READ_CELL, 10'd0, SIDE_N, 5'd0, 16'h0, 16'h0, 4'h0);
		send(ACT_READ_CELL, 10'd1023, SIDE_W, 5'd31, 16'hFFFF, 16'hFFFF, 4'hF);
		send(ACT_TICK, 10'd0, SIDE_N, 5'd0, 16'h0, 16'h0, 4'hF);
		send(ACT_READ_CELL, 10'd0, SIDE_N, 5'd0, 16'h0, 16'h0, 4'h0);
		send(ACT_READ_CELL, 10'd31, SIDE_N, 5'd0, 16'h0, 16'h0, 4'h0);
		send(ACT_READ_CELL, 10'd992, SIDE_N, 5'd0, 16'h0, 16'h0, 4'h0);
		send(ACT_READ_CELL, 10'd1023, SIDE_N, 5'd0, 16'h0, 16'h0, 4'h0);
		send(ACT_TICK, 10'd1023, SIDE_W, 5'd31, 16'hFFFF, 16'hFFFF, 4'h0);
		send(ACT_READ_CELL, 10'd0, SIDE_N, 5'd0, 16'h0, 16'h0, 4'h0);
		send(ACT_READ_CELL, 10'd33, SIDE_N, 5'd0, 16'h0, 16'h0, 4'h0);
		send(ACT_READ_CELL, 10'd1023, SIDE_N, 5'd0, 16'h0, 16'h0, 4'h0);
		settle();

		// Full diffusion with no loss at the top clamp.
		write_reg(REG_ALPHA, 17'd65536);
		write_reg(REG_BETA, 17'd65536);
		write_reg(REG_MAX, 17'h0FFFF);
		random_phase(110, 2);

		// Rates above one are taken as one; a low clamp caps every level.
		write_reg(REG_ALPHA, 17'h1FFFF);
		write_reg(REG_BETA, 17'h1FFFF);
		write_reg(REG_MAX, 17'h00800);
		random_phase(110, 2);

		// Mid rates with evaporation and a random clamp.
		write_reg(REG_ALPHA, 17'($urandom_range(1, 65535)));
		write_reg(REG_BETA, 17'($urandom_range(50000, 65535)));
		write_reg(REG_MAX, 17'($urandom_range(0, 65535)));
		random_phase(110, 2);

		// Total evaporation wipes the grid; zero clamp as well.
		write_reg(REG_ALPHA, 17'd0);
		write_reg(REG_BETA, 17'd0);
		write_reg(REG_MAX, 17'h00000);
		random_phase(100, 1);

		// Random rates to finish, clamp back at the top.
		write_reg(REG_ALPHA, 17'($urandom_range(0, 131071)));
		write_reg(REG_BETA, 17'($urandom_range(0, 131071)));
		write_reg(REG_MAX, 17'h0FFFF);
		random_phase(110, 2);

		repeat (40) @(negedge clk);
		if (sb.errors == 0 && sb.pending_levels.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> files.f
hdl/gds_pkg.sv
hdl/gds_ram.sv
hdl/grid_diffusion_stencil_top.sv
hdl/gds_checker.sv
verif/grid_diffusion_stencil_top_tb.sv
